// ===== sv/efb_pkg.sv =====
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types, constants and pin mapping functions for the EEPROM burn
// frame builder.
// ----------------------------------------------------------------------------
package efb_pkg;

	// pin and field widths
	localparam int unsigned FRAME_W   = 32;
	localparam int unsigned DATA_W    = 8;
	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned PIN_ADDR_W = 15;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned BEAT_W    = 2;

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// reset value of the rom length register
	localparam logic [LEN_W-1:0] ROM_LENGTH_RST = 16'h8000;

	// beat numbers inside a three-frame group
	localparam logic [BEAT_W-1:0] BEAT_FIRST = 2'd0;
	localparam logic [BEAT_W-1:0] BEAT_WE    = 2'd1;
	localparam logic [BEAT_W-1:0] BEAT_LAST  = 2'd2;

	// pin level constants
	localparam logic [FRAME_W-1:0] BASE_PINS = 32'h0000_010C;
	localparam logic [FRAME_W-1:0] WE_CLEAR  = 32'hFFFF_FFF7;

	// one buffered group of frames, handed from the builder to the emitter
	typedef struct packed {
		logic [FRAME_W-1:0] frame_norm;
		logic [FRAME_W-1:0] frame_we;
		logic               three;
		logic               pre_enable_n;
		logic               pre_burning;
		logic               post_enable_n;
		logic               post_burning;
	} efb_job_t;

	// remap pin order to shift-register order
	function automatic logic [FRAME_W-1:0] to_shift_order(input logic [FRAME_W-1:0] s);
		logic [FRAME_W-1:0] r;
		r = s & 32'hFFF0_00FF;
		r = r | ((s & 32'h0001_0000) << 3);
		r = r | ((s & 32'h0000_0700) << 8);
		r = r | ((s & 32'h000E_0000) >> 4);
		r = r | ((s & 32'h0000_F800) >> 3);
		return r;
	endfunction

	// spread the address over the address pins
	function automatic logic [FRAME_W-1:0] scatter_address(input logic [PIN_ADDR_W-1:0] a);
		logic [FRAME_W-1:0] w;
		logic [FRAME_W-1:0] r;
		w = {{(FRAME_W-PIN_ADDR_W){1'b0}}, a};
		r = (w << 20) & 32'h0FF0_0000;
		r = r | ((w >> 3) & 32'h0000_0060);
		r = r | ((w >> 1) & 32'h0000_0200);
		r = r | ((w >> 4) & 32'h0000_0080);
		r = r | ((w << 16) & 32'h1000_0000);
		r = r | ((w >> 9) & 32'h0000_0010);
		r = r | ((w << 15) & 32'h2000_0000);
		return r;
	endfunction

	// bit-reverse the byte and put it on the data pins
	function automatic logic [FRAME_W-1:0] place_data(input logic [DATA_W-1:0] d);
		logic [DATA_W-1:0]  v;
		logic [FRAME_W-1:0] w;
		for (int i = 0; i < DATA_W; i++) begin
			v[i] = d[DATA_W-1-i];
		end
		w = {{(FRAME_W-DATA_W){1'b0}}, v};
		return ((w << 12) & 32'h000E_0000) | ((w << 11) & 32'h0000_F800);
	endfunction

	// frame sent for a start
	localparam logic [FRAME_W-1:0] START_FRAME = to_shift_order(BASE_PINS);

endpackage

// ===== sv/efb_req_if.sv =====
// ----------------------------------------------------------------------------
// efb_req_if
// Request channel: one start or data byte transaction.
// ----------------------------------------------------------------------------
interface efb_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [efb_pkg::DATA_W-1:0]   data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ===== sv/efb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// efb_rsp_if
// Response channel: one shift-register frame per transaction.
// ----------------------------------------------------------------------------
interface efb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [efb_pkg::FRAME_W-1:0]  frame;
	logic                         last_frame;
	logic                         data_enable_n;
	logic                         burning;

	modport source (output valid, output frame, output last_frame, output data_enable_n,
		output burning, input ready);
	modport sink   (input valid, input frame, input last_frame, input data_enable_n,
		input burning, output ready);
endinterface

// ===== sv/efb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// efb_cfg_if
// Configuration write channel for the rom length register.
// ----------------------------------------------------------------------------
interface efb_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [efb_pkg::LEN_W-1:0]   rom_length;

	modport source (output valid, output rom_length, input ready);
	modport sink   (input valid, input rom_length, output ready);
endinterface

// ===== sv/eeprom_burn_frame_builder.sv =====
// ----------------------------------------------------------------------------
// eeprom_burn_frame_builder
// Builds 32-bit shift-register frames that program a 28-pin parallel
// EEPROM: one frame per start, three frames per data byte while burning.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     one transaction
//  req      in   operation, data_byte                        start or data byte
//  rsp      out  frame, last_frame, data_enable_n, burning   one frame
//  cfg      in   rom_length                                  length write
//
//  a transaction waits in the input register, then its frames leave the
//  result register at one per cycle while rsp.ready is high: one for a
//  start, three for a byte while burning, none for a byte while idle
//  a transaction waiting in the input register moves on as the last frame
//  of the group before it leaves, so an rsp stall holds req.ready low
//  asynchronous reset clears the burn state and sets rom_length to 32768
// ----------------------------------------------------------------------------
module eeprom_burn_frame_builder (
	input  logic      clk,
	input  logic      arst_n,
	efb_req_if.sink   req,
	efb_rsp_if.source rsp,
	efb_cfg_if.sink   cfg
);
	import efb_pkg::*;

	efb_job_t job;
	logic     job_valid;
	logic     job_take;

	// input register, burn state and frame construction
	efb_build u_build (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.job_take  (job_take),
		.job_valid (job_valid),
		.job       (job)
	);

	// result register and frame sequencing
	efb_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.rsp       (rsp)
	);

endmodule

// ===== sv/efb_build.sv =====
// ----------------------------------------------------------------------------
// efb_build
// Input register, burn state and frame construction. Hands one group of
// frames per useful transaction to the emitter.
// ----------------------------------------------------------------------------
module efb_build (
	input  logic              clk,
	input  logic              arst_n,
	efb_req_if.sink           req,
	efb_cfg_if.sink           cfg,
	input  logic              job_take,
	output logic              job_valid,
	output efb_pkg::efb_job_t job
);
	import efb_pkg::*;

	logic                valid_s1;
	logic                operation_s1;
	logic [DATA_W-1:0]   data_s1;
	logic [ADDR_W-1:0]   addr_q;
	logic                active_q;
	logic                enable_n_q;
	logic [LEN_W-1:0]    rom_length_q;

	logic                advance;
	logic [ADDR_W-1:0]   addr_next;
	logic                burn_done;
	logic [FRAME_W-1:0]  pins;

	// item leaves the input register once the emitter can take its frames
	assign advance   = valid_s1 && job_take;
	assign req.ready = !valid_s1 || job_take;
	assign cfg.ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			operation_s1 <= req.operation;
			data_s1      <= req.data_byte;
		end
	end

	// rom length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_length_q <= ROM_LENGTH_RST;
		end else if (cfg.valid && cfg.ready) begin
			rom_length_q <= cfg.rom_length;
		end
	end

	// address step and end of burn check
	assign addr_next = addr_q + ADDR_W'(1);
	assign burn_done = addr_next >= rom_length_q;

	// pin pattern for a data byte
	assign pins = BASE_PINS | scatter_address(addr_q[PIN_ADDR_W-1:0]) | place_data(data_s1);

	// frame group
	always_comb begin
		job = '0;
		if (operation_s1 == OP_START) begin
			job.frame_norm    = START_FRAME;
			job.frame_we      = START_FRAME;
			job.three         = 1'b0;
			job.pre_enable_n  = 1'b0;
			job.pre_burning   = 1'b1;
			job.post_enable_n = 1'b0;
			job.post_burning  = 1'b1;
		end else begin
			job.frame_norm    = to_shift_order(pins);
			job.frame_we      = to_shift_order(pins & WE_CLEAR);
			job.three         = 1'b1;
			job.pre_enable_n  = enable_n_q;
			job.pre_burning   = active_q;
			job.post_enable_n = burn_done ? 1'b1 : enable_n_q;
			job.post_burning  = burn_done ? 1'b0 : active_q;
		end
	end

	// bytes while idle are dropped
	assign job_valid = valid_s1 && ((operation_s1 == OP_START) || active_q);

	// burn state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			active_q   <= 1'b0;
			enable_n_q <= 1'b1;
		end else if (advance) begin
			if (operation_s1 == OP_START) begin
				addr_q     <= '0;
				active_q   <= 1'b1;
				enable_n_q <= 1'b0;
			end else if (active_q) begin
				addr_q <= addr_next;
				if (burn_done) begin
					active_q   <= 1'b0;
					enable_n_q <= 1'b1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// data enable is driven exactly while a burn runs
	a_enable_tracks_active: assert property (@(posedge clk) disable iff (!arst_n)
		enable_n_q != active_q)
		else $error("data enable out of step with burn state");

	// a start always leaves the address at zero with burning set
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && operation_s1 == OP_START |=> addr_q == '0 && active_q)
		else $error("start did not restart the burn");

	// a waiting transaction is held unchanged in the input register
	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !job_take |=> valid_s1 && $stable(operation_s1) && $stable(data_s1))
		else $error("input register changed while waiting");
`endif

endmodule

// ===== sv/efb_emit.sv =====
// ----------------------------------------------------------------------------
// efb_emit
// Result register holding one frame group, sent one frame per transaction.
// ----------------------------------------------------------------------------
module efb_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  efb_pkg::efb_job_t job,
	output logic              job_take,
	efb_rsp_if.source         rsp
);
	import efb_pkg::*;

	efb_job_t          job_q;
	logic              valid_q;
	logic [BEAT_W-1:0] beat_q;
	logic              last_beat;
	logic              fire;

	assign last_beat = job_q.three ? (beat_q == BEAT_LAST) : (beat_q == BEAT_FIRST);
	assign fire      = rsp.valid && rsp.ready;
	assign job_take  = !valid_q || (fire && last_beat);

	// result register and beat count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_FIRST;
		end else if (job_take) begin
			valid_q <= job_valid;
			beat_q  <= BEAT_FIRST;
		end else if (fire) begin
			beat_q <= beat_q + BEAT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_take && job_valid) begin
			job_q <= job;
		end
	end

	// frame and status for the current beat
	assign rsp.valid         = valid_q;
	assign rsp.frame         = (beat_q == BEAT_WE) ? job_q.frame_we : job_q.frame_norm;
	assign rsp.last_frame    = last_beat;
	assign rsp.data_enable_n = last_beat ? job_q.post_enable_n : job_q.pre_enable_n;
	assign rsp.burning       = last_beat ? job_q.post_burning : job_q.pre_burning;

`ifndef NO_ASSERTIONS
	// a single-frame group never steps past its first beat
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !job_q.three |-> beat_q == BEAT_FIRST)
		else $error("single frame group past first beat");

	// beat count stays within a three-frame group
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q == BEAT_FIRST || beat_q == BEAT_WE || beat_q == BEAT_LAST)
		else $error("beat count out of range");

	// the count restarts after the final frame leaves
	a_beat_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_beat |=> beat_q == BEAT_FIRST)
		else $error("beat count not restarted after final frame");
`endif

endmodule
